[hdl/fr_pkg.sv]
// Package for the fraction reducer: data width, control word and flag types,
// and the microcode table that sequences the datapath.
// No dependencies; imported by every module of the block.
`default_nettype none

package fr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
   localparam int PC_WIDTH   = 4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_GSTEP,
      OP_GFIN,
      OP_DSTEP,
      OP_DNUM,
      OP_DDEN,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NOSTART,
      C_TRIVIAL,
      C_GCDBUSY,
      C_DIVBUSY,
      C_OUTFREE
   } cond_type;

   localparam logic [PC_WIDTH-1:0] STEP_IDLE  = PC_WIDTH'(0);
   localparam logic [PC_WIDTH-1:0] STEP_CHECK = PC_WIDTH'(1);
   localparam logic [PC_WIDTH-1:0] STEP_GCD   = PC_WIDTH'(2);
   localparam logic [PC_WIDTH-1:0] STEP_GFIN  = PC_WIDTH'(3);
   localparam logic [PC_WIDTH-1:0] STEP_DIVN  = PC_WIDTH'(4);
   localparam logic [PC_WIDTH-1:0] STEP_NEXT  = PC_WIDTH'(5);
   localparam logic [PC_WIDTH-1:0] STEP_DIVD  = PC_WIDTH'(6);
   localparam logic [PC_WIDTH-1:0] STEP_DDEN  = PC_WIDTH'(7);
   localparam logic [PC_WIDTH-1:0] STEP_EMIT  = PC_WIDTH'(8);
   localparam logic [PC_WIDTH-1:0] STEP_WAIT  = PC_WIDTH'(9);

   typedef struct packed {
      op_type                op;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
   } ctrl_word_type;

   typedef struct packed {
      logic trivial;
      logic gcd_busy;
      logic div_busy;
   } dp_flags_type;

   // One control word per step: the operation, and where to go when the
   // condition holds (otherwise the next step follows).
   function automatic ctrl_word_type microcode(input logic [PC_WIDTH-1:0] step);
      ctrl_word_type w;
      w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE};
      case (step)
         STEP_IDLE:  w = '{op: OP_LOAD,  cond: C_NOSTART, target: STEP_IDLE};
         STEP_CHECK: w = '{op: OP_NONE,  cond: C_TRIVIAL, target: STEP_EMIT};
         STEP_GCD:   w = '{op: OP_GSTEP, cond: C_GCDBUSY, target: STEP_GCD};
         STEP_GFIN:  w = '{op: OP_GFIN,  cond: C_NEVER,   target: STEP_IDLE};
         STEP_DIVN:  w = '{op: OP_DSTEP, cond: C_DIVBUSY, target: STEP_DIVN};
         STEP_NEXT:  w = '{op: OP_DNUM,  cond: C_NEVER,   target: STEP_IDLE};
         STEP_DIVD:  w = '{op: OP_DSTEP, cond: C_DIVBUSY, target: STEP_DIVD};
         STEP_DDEN:  w = '{op: OP_DDEN,  cond: C_NEVER,   target: STEP_IDLE};
         STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUTFREE, target: STEP_IDLE};
         STEP_WAIT:  w = '{op: OP_NONE,  cond: C_ALWAYS,  target: STEP_EMIT};
         default:    w = '{op: OP_NONE,  cond: C_ALWAYS,  target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[hdl/fr_sequencer.sv]
// Microcode sequencer: step counter, table lookup and conditional jumps.
// Depends on fr_pkg for the control word, the flags and the table.
`default_nettype none

module fr_sequencer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             out_free,
   input  wire fr_pkg::dp_flags_type flags,
   output fr_pkg::op_type        op
);
   import fr_pkg::*;

   logic [PC_WIDTH-1:0] pc_ff;
   logic [PC_WIDTH-1:0] pc_in;
   ctrl_word_type       word;
   logic                jump;

   always_comb begin
      word = microcode(pc_ff);
      case (word.cond)
         C_NEVER:   jump = 1'b0;
         C_ALWAYS:  jump = 1'b1;
         C_NOSTART: jump = !start;
         C_TRIVIAL: jump = flags.trivial;
         C_GCDBUSY: jump = flags.gcd_busy;
         C_DIVBUSY: jump = flags.div_busy;
         C_OUTFREE: jump = out_free;
         default:   jump = 1'b0;
      endcase
      pc_in = jump ? word.target : pc_ff + 1'b1;
   end

   assign op = word.op;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

[hdl/fr_datapath.sv]
// Datapath: sign/magnitude split, binary GCD and a shared restoring divider.
// Depends on fr_pkg; steered one operation per cycle by fr_sequencer.
`default_nettype none

module fr_datapath (
   input  wire logic                           clock,
   input  wire fr_pkg::op_type                 op,
   input  wire logic [fr_pkg::DATA_WIDTH-1:0]  in_num,
   input  wire logic [fr_pkg::DATA_WIDTH-1:0]  in_den,
   output fr_pkg::dp_flags_type                flags,
   output logic [fr_pkg::DATA_WIDTH-1:0]       res_num,
   output logic [fr_pkg::DATA_WIDTH-1:0]       res_den
);
   import fr_pkg::*;

   logic                  nneg_ff, dneg_ff;
   logic [DATA_WIDTH-1:0] na_ff, da_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;
   logic [CNT_WIDTH-1:0]  k_ff;
   logic [DATA_WIDTH-1:0] g_ff;
   logic [DATA_WIDTH-1:0] x_ff;
   logic [DATA_WIDTH-1:0] r_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;

   logic [DATA_WIDTH-1:0] mag_n, mag_d;
   logic [DATA_WIDTH:0]   r_shift, r_diff;
   logic                  q_bit;

   assign mag_n = in_num[DATA_WIDTH-1] ? DATA_WIDTH'(0) - in_num : in_num;
   assign mag_d = in_den[DATA_WIDTH-1] ? DATA_WIDTH'(0) - in_den : in_den;

   // One restoring division step: shift in the next dividend bit, try the subtract.
   assign r_shift = {r_ff, x_ff[DATA_WIDTH-1]};
   assign r_diff  = r_shift - {1'b0, g_ff};
   assign q_bit   = !r_diff[DATA_WIDTH];

   assign flags.trivial  = (na_ff <= DATA_WIDTH'(1)) || (da_ff <= DATA_WIDTH'(1));
   assign flags.gcd_busy = (a_ff != '0) && (b_ff != '0);
   assign flags.div_busy = (cnt_ff != CNT_WIDTH'(DATA_WIDTH - 1));

   assign res_num = nneg_ff ? DATA_WIDTH'(0) - na_ff : na_ff;
   assign res_den = dneg_ff ? DATA_WIDTH'(0) - da_ff : da_ff;

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            nneg_ff <= in_num[DATA_WIDTH-1];
            dneg_ff <= in_den[DATA_WIDTH-1];
            na_ff   <= mag_n;
            da_ff   <= mag_d;
            a_ff    <= mag_n;
            b_ff    <= mag_d;
            k_ff    <= '0;
         end
         OP_GSTEP: begin
            if (flags.gcd_busy) begin
               if (!a_ff[0] && !b_ff[0]) begin
                  a_ff <= a_ff >> 1;
                  b_ff <= b_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else if (!a_ff[0]) begin
                  a_ff <= a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_ff <= b_ff >> 1;
               end else if (a_ff >= b_ff) begin
                  a_ff <= a_ff - b_ff;
               end else begin
                  b_ff <= b_ff - a_ff;
               end
            end
         end
         OP_GFIN: begin
            // One of the pair is now zero, the other holds the odd part.
            g_ff   <= (a_ff | b_ff) << k_ff;
            x_ff   <= na_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_DSTEP: begin
            r_ff   <= q_bit ? r_diff[DATA_WIDTH-1:0] : r_shift[DATA_WIDTH-1:0];
            x_ff   <= {x_ff[DATA_WIDTH-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
         end
         OP_DNUM: begin
            na_ff  <= x_ff;
            x_ff   <= da_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_DDEN: begin
            da_ff <= x_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/fraction_reducer.sv]
// Fraction reducer top level: one item in, one reduced item out; uses fr_pkg, fr_sequencer
// and fr_datapath. When either magnitude is 0 or 1 the item is passed out unchanged;
// otherwise a binary GCD runs, then two DATA_WIDTH-step divisions on the shared divider
// divide the numerator and the denominator by the GCD.
// One item is in work at a time: the next is taken on the idle step after the emit step.
// Synchronous active-high reset clears the step counter and output valid, and stalls input.
`default_nettype none

module fraction_reducer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [fr_pkg::DATA_WIDTH-1:0]  req_numerator,
   input  wire logic signed [fr_pkg::DATA_WIDTH-1:0]  req_denominator,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [fr_pkg::DATA_WIDTH-1:0]       rsp_reduced_numerator,
   output logic signed [fr_pkg::DATA_WIDTH-1:0]       rsp_reduced_denominator
);
   import fr_pkg::*;

   op_type                op;
   dp_flags_type          flags;
   logic [DATA_WIDTH-1:0] res_num, res_den;
   logic                  out_free;
   logic                  emit_load;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_num_ff, rsp_den_ff;

   // The block takes a new item only while the sequencer sits on its idle
   // step; the datapath loads the input ports on that step every cycle, so
   // the registers hold the item from the edge at which it is accepted.
   // While reset is high nothing is taken.
   assign req_stall = reset || (op != OP_LOAD);

   // The output register frees itself when its item is taken, so a finished
   // result can leave in the same cycle the next one is written.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = (op == OP_EMIT) && out_free;

   fr_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .out_free (out_free),
      .flags    (flags),
      .op       (op)
   );

   fr_datapath u_datapath (
      .clock   (clock),
      .op      (op),
      .in_num  (req_numerator),
      .in_den  (req_denominator),
      .flags   (flags),
      .res_num (res_num),
      .res_den (res_den)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload needs no reset; it is only looked at while valid is high.
   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_num_ff <= res_num;
         rsp_den_ff <= res_den;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_reduced_numerator   = rsp_num_ff;
   assign rsp_reduced_denominator = rsp_den_ff;

endmodule

`default_nettype wire
